FILE: hdl/msp_pkg.sv
// Shared types, constants and helpers of the matrix saddle point finder.
package msp_pkg;

    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 128;

    localparam int VAL_W     = 31;
    localparam int CNT_W     = 8;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [ROW_CNT_W-1:0] rows;
        logic [COL_CNT_W-1:0] cols;
    } dims_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ROW_W-1:0] ri;
        logic [COL_W-1:0] ci;
        logic             first_row;
        logic             first_col;
        logic             row_end;
        logic             last;
    } ld_item_t;

    typedef struct packed {
        logic                  empty;
        logic                  full;
        logic [FIFO_LVL_W-1:0] level;
    } fifo_stat_t;

    function automatic logic [ROW_CNT_W-1:0] clamp_rows(logic [CNT_W-1:0] c);
        if (c == '0) begin
            return ROW_CNT_W'(1);
        end
        if (32'(c) > MAX_ROWS) begin
            return ROW_CNT_W'(MAX_ROWS);
        end
        return ROW_CNT_W'(c);
    endfunction

    function automatic logic [COL_CNT_W-1:0] clamp_cols(logic [CNT_W-1:0] c);
        if (c == '0) begin
            return COL_CNT_W'(1);
        end
        if (32'(c) > MAX_COLS) begin
            return COL_CNT_W'(MAX_COLS);
        end
        return COL_CNT_W'(c);
    endfunction

endpackage

FILE: hdl/matrix_saddle_point_finder_top.sv
// Throughput: elements load at one per cycle while the back end is loading and its queue is not empty;
// the column maximum read-modify-write is one per cycle. The scan then reads the element store once per entry,
// in row-major order, and stops at the first saddle point it finds.
// Up to four elements of the next matrix are queued while the scan runs or the result waits.
// Reset (aresetn low, synchronous) clears control, the queue and load position; counts go to 1.
module matrix_saddle_point_finder_top
    import msp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wdata,
    // element stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [30:0] element_value, [31] zero
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [30:0] saddle_value, [31] zero
    output logic                 m_tuser    // [0] found
);

    dims_t            dims;
    logic             fifo_push;
    ld_item_t         fifo_push_item;
    logic             fifo_pop;
    ld_item_t         fifo_pop_item;
    fifo_stat_t       fifo_stat;
    logic             res_found;
    logic [VAL_W-1:0] res_value;

    // accept a transaction whenever the queue has room
    assign s_tready = !fifo_stat.full;

    // tag each element with its matrix position and hold the counts
    msp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_value  (s_tdata[VAL_W-1:0]),
        .fifo_full (fifo_stat.full),
        .push      (fifo_push),
        .push_item (fifo_push_item),
        .dims      (dims)
    );

    // decouple intake from the load pipeline and the scan
    msp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_item (fifo_push_item),
        .pop       (fifo_pop),
        .pop_item  (fifo_pop_item),
        .stat      (fifo_stat)
    );

    // store elements, track extremes, scan and hold the result transaction
    msp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dims       (dims),
        .fifo_empty (fifo_stat.empty),
        .fifo_item  (fifo_pop_item),
        .pop        (fifo_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_found  (res_found),
        .res_value  (res_value)
    );

    assign m_tdata = {1'b0, res_value};
    assign m_tuser = res_found;

    // queue level never passes its depth
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.level <= FIFO_LVL_W'(FIFO_DEPTH))
        else $error("queue level above depth");

    // no element enters the load pipeline while a result waits
    a_hold_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !fifo_pop)
        else $error("load advanced while result pending");

    // one result per matrix: a taken result is not followed by another at once
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("back-to-back results");

    // a not-found result carries a zero value
    a_zero_when_missing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[30:0] == '0))
        else $error("nonzero value without saddle point");

endmodule

FILE: hdl/msp_front.sv
// Front end: configuration registers, load position tracking and item tagging.
module msp_front
    import msp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic [VAL_W-1:0]     in_value,
    input  logic                 fifo_full,
    output logic                 push,
    output ld_item_t             push_item,
    output dims_t                dims
);

    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] ri_reg, ri_next;
    logic [COL_W-1:0] ci_reg, ci_next;
    logic             row_end;
    logic             last;

    assign dims.rows = clamp_rows(row_cnt_reg);
    assign dims.cols = clamp_cols(col_cnt_reg);

    assign push    = in_valid && !fifo_full;
    assign row_end = (COL_CNT_W'(ci_reg) == dims.cols - COL_CNT_W'(1));
    assign last    = row_end && (ROW_CNT_W'(ri_reg) == dims.rows - ROW_CNT_W'(1));

    assign push_item.value     = in_value;
    assign push_item.ri        = ri_reg;
    assign push_item.ci        = ci_reg;
    assign push_item.first_row = (ri_reg == '0);
    assign push_item.first_col = (ci_reg == '0);
    assign push_item.row_end   = row_end;
    assign push_item.last      = last;

    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        ri_next      = ri_reg;
        ci_next      = ci_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROW_COUNT: begin
                    row_cnt_next = cfg_wdata;
                    ri_next      = '0;
                    ci_next      = '0;
                end
                CFG_COL_COUNT: begin
                    col_cnt_next = cfg_wdata;
                    ri_next      = '0;
                    ci_next      = '0;
                end
                default: ;
            endcase
        end else if (push) begin
            if (last) begin
                ri_next = '0;
                ci_next = '0;
            end else if (row_end) begin
                ri_next = ri_reg + 1'b1;
                ci_next = '0;
            end else begin
                ci_next = ci_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= CNT_W'(1);
            col_cnt_reg <= CNT_W'(1);
            ri_reg      <= '0;
            ci_reg      <= '0;
        end else begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            ri_reg      <= ri_next;
            ci_reg      <= ci_next;
        end
    end

endmodule

FILE: hdl/msp_fifo.sv
// Short queue of tagged load items between the front end and the back end.
module msp_fifo
    import msp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ld_item_t   push_item,
    input  logic       pop,
    output ld_item_t   pop_item,
    output fifo_stat_t stat
);

    ld_item_t              slot_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0] level_reg, level_next;

    assign stat.empty = (level_reg == '0);
    assign stat.full  = (level_reg == FIFO_LVL_W'(FIFO_DEPTH));
    assign stat.level = level_reg;
    assign pop_item   = slot_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

FILE: hdl/msp_back.sv
// Back end: element store, row minimum and column maximum memories, scan and result.
module msp_back
    import msp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  dims_t            dims,
    input  logic             fifo_empty,
    input  ld_item_t         fifo_item,
    output logic             pop,
    output logic             res_valid,
    input  logic             res_ready,
    output logic             res_found,
    output logic [VAL_W-1:0] res_value
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [VAL_W-1:0] elem_mem [MAX_ROWS][MAX_COLS];
    logic [VAL_W-1:0] rmin_mem [MAX_ROWS];
    logic [VAL_W-1:0] cmax_mem [MAX_COLS];

    logic [1:0]       state_reg, state_next;
    logic             ld_valid_reg, ld_valid_next;
    ld_item_t         ld_item_reg, ld_item_next;
    logic             fwd_reg, fwd_next;
    logic [VAL_W-1:0] fwd_data_reg, fwd_data_next;
    logic [VAL_W-1:0] rmin_reg, rmin_next;
    logic             issue_reg, issue_next;
    logic [ROW_W-1:0] scan_i_reg, scan_i_next;
    logic [COL_W-1:0] scan_j_reg, scan_j_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             cmp_last_reg, cmp_last_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;
    logic [VAL_W-1:0] elem_rd_reg, rmin_rd_reg, cmax_rd_reg;

    logic [COL_W-1:0] cmax_raddr;
    logic [VAL_W-1:0] cmax_in;
    logic [VAL_W-1:0] cmax_new;
    logic [VAL_W-1:0] rmin_new;
    logic             scan_row_end;
    logic             scan_last;
    logic             hit;

    assign pop = (state_reg == ST_LOAD) && !fifo_empty && !(ld_valid_reg && ld_item_reg.last);

    assign cmax_raddr = (state_reg == ST_SCAN) ? scan_j_reg : fifo_item.ci;

    // forwarded value covers a write to the same column at the read edge
    assign cmax_in  = fwd_reg ? fwd_data_reg : cmax_rd_reg;
    assign cmax_new = (ld_item_reg.first_row || ld_item_reg.value > cmax_in)
                      ? ld_item_reg.value : cmax_in;
    assign rmin_new = (ld_item_reg.first_col || ld_item_reg.value < rmin_reg)
                      ? ld_item_reg.value : rmin_reg;

    assign scan_row_end = (COL_CNT_W'(scan_j_reg) == dims.cols - COL_CNT_W'(1));
    assign scan_last    = scan_row_end
                          && (ROW_CNT_W'(scan_i_reg) == dims.rows - ROW_CNT_W'(1));
    assign hit = cmp_valid_reg && (elem_rd_reg == rmin_rd_reg) && (elem_rd_reg == cmax_rd_reg);

    assign res_valid = out_valid_reg;
    assign res_found = out_found_reg;
    assign res_value = out_value_reg;

    always_comb begin
        state_next     = state_reg;
        ld_valid_next  = pop;
        ld_item_next   = pop ? fifo_item : ld_item_reg;
        fwd_next       = pop && ld_valid_reg && (ld_item_reg.ci == fifo_item.ci);
        fwd_data_next  = cmax_new;
        rmin_next      = ld_valid_reg ? rmin_new : rmin_reg;
        issue_next     = issue_reg;
        scan_i_next    = scan_i_reg;
        scan_j_next    = scan_j_reg;
        cmp_valid_next = 1'b0;
        cmp_last_next  = 1'b0;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_value_next = out_value_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (ld_valid_reg && ld_item_reg.last) begin
                    state_next  = ST_SCAN;
                    issue_next  = 1'b1;
                    scan_i_next = '0;
                    scan_j_next = '0;
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_last_next  = scan_last;
                    if (scan_last) begin
                        issue_next = 1'b0;
                    end
                    if (scan_row_end) begin
                        scan_j_next = '0;
                        scan_i_next = scan_i_reg + 1'b1;
                    end else begin
                        scan_j_next = scan_j_reg + 1'b1;
                    end
                end
                // stop at the first hit in row-major order
                if (hit) begin
                    state_next     = ST_OUT;
                    issue_next     = 1'b0;
                    cmp_valid_next = 1'b0;
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                    out_value_next = elem_rd_reg;
                end else if (cmp_valid_reg && cmp_last_reg) begin
                    state_next     = ST_OUT;
                    issue_next     = 1'b0;
                    cmp_valid_next = 1'b0;
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_value_next = '0;
                end
            end
            ST_OUT: begin
                if (res_ready) begin
                    out_valid_next = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ld_valid_reg) begin
            elem_mem[ld_item_reg.ri][ld_item_reg.ci] <= ld_item_reg.value;
            cmax_mem[ld_item_reg.ci] <= cmax_new;
            if (ld_item_reg.row_end) begin
                rmin_mem[ld_item_reg.ri] <= rmin_new;
            end
        end
        elem_rd_reg <= elem_mem[scan_i_reg][scan_j_reg];
        rmin_rd_reg <= rmin_mem[scan_i_reg];
        cmax_rd_reg <= cmax_mem[cmax_raddr];
    end

    always_ff @(posedge aclk) begin
        ld_item_reg   <= ld_item_next;
        fwd_data_reg  <= fwd_data_next;
        rmin_reg      <= rmin_next;
        out_found_reg <= out_found_next;
        out_value_reg <= out_value_next;
        scan_i_reg    <= scan_i_next;
        scan_j_reg    <= scan_j_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            ld_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ld_valid_reg  <= ld_valid_next;
            fwd_reg       <= fwd_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
